// ===== rtl/core/hybrid_branch_direction_predictor_unit_macros.svh =====
// Assertion macros for the hybrid branch direction predictor.
// Depends on clk_i and rst_ni being visible in the module that uses them.
`ifndef HYBRID_BRANCH_DIRECTION_PREDICTOR_UNIT_MACROS_SVH
`define HYBRID_BRANCH_DIRECTION_PREDICTOR_UNIT_MACROS_SVH

// Antecedent implies consequent, checked on every clock edge out of reset.
`define HBDP_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// The condition never holds.
`define HBDP_ASSERT_NEVER(label, cond, msg) \
  `HBDP_ASSERT_IMPL(label, 1'b1, !(cond), msg)

`endif

// ===== rtl/core/hbdp_pkg.sv =====
// Package for the hybrid branch direction predictor.
// Holds counter constants and saturating counter functions; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package hbdp_pkg;

  localparam logic [1:0] Cnt2Reset   = 2'd2;
  localparam logic [1:0] Cnt2Max     = 2'd3;
  localparam logic [1:0] Cnt2Taken   = 2'd2;
  localparam logic [2:0] Cnt3Reset   = 3'd4;
  localparam logic [2:0] Cnt3Max     = 3'd7;
  localparam logic [2:0] Cnt3Taken   = 3'd4;
  localparam logic [1:0] ChooseReset = 2'd1;

  // Two-bit saturating counter step.
  function automatic logic [1:0] sat2(input logic [1:0] v, input logic up);
    logic [1:0] r;
    if (up) begin
      r = (v == Cnt2Max) ? v : v + 2'd1;
    end else begin
      r = (v == 2'd0) ? v : v - 2'd1;
    end
    return r;
  endfunction

  // Three-bit saturating counter step.
  function automatic logic [2:0] sat3(input logic [2:0] v, input logic up);
    logic [2:0] r;
    if (up) begin
      r = (v == Cnt3Max) ? v : v + 3'd1;
    end else begin
      r = (v == 3'd0) ? v : v - 3'd1;
    end
    return r;
  endfunction

  // A chooser moves toward the component that was right when only one side was right.
  function automatic logic [1:0] train(input logic [1:0] c, input logic lo_ok,
                                       input logic hi_ok);
    return (lo_ok != hi_ok) ? sat2(c, hi_ok) : c;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/hbdp_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module hbdp_ram #(
  parameter int WIDTH = 2,
  parameter int DEPTH = 512
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port and registered read port; a read beside a write returns old data.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ===== rtl/core/hbdp_fwd.sv =====
// Last-write bypass for a RAM whose read was issued at the edge of that write.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module hbdp_fwd #(
  parameter int AW = 9,
  parameter int DW = 2
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          we_i,
  input  wire logic [AW-1:0] waddr_i,
  input  wire logic [DW-1:0] wdata_i,
  input  wire logic [AW-1:0] raddr_i,
  input  wire logic [DW-1:0] rdata_i,
  output logic      [DW-1:0] data_o
);

  logic          valid_q;
  logic [AW-1:0] addr_q;
  logic [DW-1:0] data_q;

  // Remember the most recent write.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (we_i) begin
      valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      addr_q <= waddr_i;
      data_q <= wdata_i;
    end
  end

  // A matching recent write is at least as new as the RAM data.
  assign data_o = (valid_q && (addr_q == raddr_i)) ? data_q : rdata_i;

endmodule

`default_nettype wire

// ===== rtl/core/hybrid_branch_direction_predictor_unit.sv =====
// Channel | Direction | Handshake              | Payload
// in      | input     | in_valid_i / in_stall_o   | branch_addr_i, outcome_taken_i, is_forward_i
// out     | output    | out_valid_o / out_stall_i | pred_*_o (eight one-bit predictions)
// One branch a cycle unless clearing or stalled; beats reach the output register after stage two.
// Stage one reads and updates the local history, stage two updates the pattern tables.
// After reset a clearing pass over max(TABLE_ENTRIES, LOCAL_ENTRIES) addresses fills the tables.
// A stalled output freezes the whole pipeline and its RAM read ports.
// Table sizes must be powers of two (unchecked); indexes use low address, history or XOR bits.
`timescale 1ns / 1ps
`default_nettype none
`include "hybrid_branch_direction_predictor_unit_macros.svh"

module hybrid_branch_direction_predictor_unit
  import hbdp_pkg::*;
#(
  parameter int TABLE_ENTRIES = 512,
  parameter int LOCAL_ENTRIES = 1024,
  parameter int HISTORY_BITS  = 9
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_stall_o,
  input  wire logic [9:0] branch_addr_i,
  input  wire logic       outcome_taken_i,
  input  wire logic       is_forward_i,
  output logic            out_valid_o,
  input  wire logic       out_stall_i,
  output logic            pred_static_o,
  output logic            pred_bimodal_o,
  output logic            pred_local_o,
  output logic            pred_global_o,
  output logic            pred_xor_global_o,
  output logic            pred_chooser_two_o,
  output logic            pred_majority_o,
  output logic            pred_tourney_o
);

  localparam int IW   = $clog2(TABLE_ENTRIES);
  localparam int LW   = $clog2(LOCAL_ENTRIES);
  localparam int HB   = HISTORY_BITS;
  localparam int MAXE = (TABLE_ENTRIES > LOCAL_ENTRIES) ? TABLE_ENTRIES : LOCAL_ENTRIES;
  localparam int CLW  = $clog2(MAXE);
  localparam logic [8:0] GpcReset = {ChooseReset, ChooseReset, ChooseReset, Cnt3Reset};

  logic adv, acc;

  // Clearing pass after reset.
  logic           clr_q;
  logic [CLW-1:0] cnt_q;
  logic           clr_t, clr_l;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q <= 1'b1;
      cnt_q <= '0;
    end else if (clr_q) begin
      cnt_q <= cnt_q + 1'b1;
      if (cnt_q == CLW'(MAXE - 1)) begin
        clr_q <= 1'b0;
      end
    end
  end

  assign clr_t = clr_q && ({1'b0, cnt_q} < (CLW + 1)'(TABLE_ENTRIES));
  assign clr_l = clr_q && ({1'b0, cnt_q} < (CLW + 1)'(LOCAL_ENTRIES));

  // Handshake: the whole pipeline moves when the output register can take a beat.
  logic out_valid_q;
  assign adv        = !out_valid_q || !out_stall_i;
  assign in_stall_o = clr_q || !adv;
  assign acc        = in_valid_i && !in_stall_o;

  // Global history is updated as soon as a beat is accepted.
  logic [HB-1:0] gh_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gh_q <= '0;
    end else if (acc) begin
      gh_q <= {gh_q[HB-2:0], outcome_taken_i};
    end
  end

  // Index forming for the accepted beat.
  logic [31:0]   addr_ext, xor_ext, gh_ext;
  logic [IW-1:0] bi0, gi0, xi0;
  logic [LW-1:0] li0;
  assign addr_ext = 32'(branch_addr_i);
  assign gh_ext   = 32'(gh_q);
  assign xor_ext  = addr_ext ^ gh_ext;
  assign bi0      = addr_ext[IW-1:0];
  assign li0      = addr_ext[LW-1:0];
  assign gi0      = gh_ext[IW-1:0];
  assign xi0      = xor_ext[IW-1:0];

  // Stage one registers.
  logic          s1_valid_q, s1_taken_q, s1_fwd_q;
  logic [IW-1:0] s1_bi_q, s1_gi_q, s1_xi_q;
  logic [LW-1:0] s1_li_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (adv) begin
      s1_valid_q <= acc;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_taken_q <= outcome_taken_i;
      s1_fwd_q   <= is_forward_i;
      s1_bi_q    <= bi0;
      s1_gi_q    <= gi0;
      s1_xi_q    <= xi0;
      s1_li_q    <= li0;
    end
  end

  // Local history read, bypass and write back in stage one.
  logic [HB-1:0] lh_raw, lh_cur, lh_new;
  logic [HB-1:0] lhw_data_q;
  logic [LW-1:0] lhw_addr_q;
  logic          lhw_valid_q;
  logic          lh_we;
  logic [IW-1:0] lp1;
  logic [31:0]   lh_ext;

  assign lh_we  = adv && s1_valid_q;
  assign lh_cur = (lhw_valid_q && (lhw_addr_q == s1_li_q)) ? lhw_data_q : lh_raw;
  assign lh_new = {lh_cur[HB-2:0], s1_taken_q};
  assign lh_ext = 32'(lh_cur);
  assign lp1    = lh_ext[IW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lhw_valid_q <= 1'b0;
    end else if (lh_we) begin
      lhw_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (lh_we) begin
      lhw_addr_q <= s1_li_q;
      lhw_data_q <= lh_new;
    end
  end

  hbdp_ram #(.WIDTH(HB), .DEPTH(LOCAL_ENTRIES)) u_lh_ram (
    .clk_i   (clk_i),
    .we_i    (clr_l || lh_we),
    .waddr_i (clr_q ? cnt_q[LW-1:0] : s1_li_q),
    .wdata_i (clr_q ? '0 : lh_new),
    .re_i    (adv),
    .raddr_i (li0),
    .rdata_o (lh_raw)
  );

  // Stage two registers.
  logic          s2_valid_q, s2_taken_q, s2_fwd_q;
  logic [IW-1:0] s2_bi_q, s2_gi_q, s2_xi_q, s2_lp_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else if (adv) begin
      s2_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s2_taken_q <= s1_taken_q;
      s2_fwd_q   <= s1_fwd_q;
      s2_bi_q    <= s1_bi_q;
      s2_gi_q    <= s1_gi_q;
      s2_xi_q    <= s1_xi_q;
      s2_lp_q    <= lp1;
    end
  end

  // Pattern tables: read at the end of stage one, updated in stage two.
  logic          tb_we;
  logic [1:0]    bim_raw, bim_cur, bim_new, lpt_raw, lpt_cur, lpt_new;
  logic [2:0]    xpt_raw, xpt_cur, xpt_new;
  logic [8:0]    gpc_raw, gpc_cur, gpc_new;
  logic [IW-1:0] clr_a;

  assign tb_we = adv && s2_valid_q;
  assign clr_a = cnt_q[IW-1:0];

  hbdp_ram #(.WIDTH(2), .DEPTH(TABLE_ENTRIES)) u_bim_ram (
    .clk_i   (clk_i),
    .we_i    (clr_t || tb_we),
    .waddr_i (clr_q ? clr_a : s2_bi_q),
    .wdata_i (clr_q ? Cnt2Reset : bim_new),
    .re_i    (adv),
    .raddr_i (s1_bi_q),
    .rdata_o (bim_raw)
  );

  hbdp_ram #(.WIDTH(2), .DEPTH(TABLE_ENTRIES)) u_lpt_ram (
    .clk_i   (clk_i),
    .we_i    (clr_t || tb_we),
    .waddr_i (clr_q ? clr_a : s2_lp_q),
    .wdata_i (clr_q ? Cnt2Reset : lpt_new),
    .re_i    (adv),
    .raddr_i (lp1),
    .rdata_o (lpt_raw)
  );

  hbdp_ram #(.WIDTH(3), .DEPTH(TABLE_ENTRIES)) u_xpt_ram (
    .clk_i   (clk_i),
    .we_i    (clr_t || tb_we),
    .waddr_i (clr_q ? clr_a : s2_xi_q),
    .wdata_i (clr_q ? Cnt3Reset : xpt_new),
    .re_i    (adv),
    .raddr_i (s1_xi_q),
    .rdata_o (xpt_raw)
  );

  // Global pattern counter and the three choosers share the history index.
  hbdp_ram #(.WIDTH(9), .DEPTH(TABLE_ENTRIES)) u_gpc_ram (
    .clk_i   (clk_i),
    .we_i    (clr_t || tb_we),
    .waddr_i (clr_q ? clr_a : s2_gi_q),
    .wdata_i (clr_q ? GpcReset : gpc_new),
    .re_i    (adv),
    .raddr_i (s1_gi_q),
    .rdata_o (gpc_raw)
  );

  hbdp_fwd #(.AW(IW), .DW(2)) u_bim_fwd (
    .clk_i (clk_i), .rst_ni (rst_ni), .we_i (tb_we), .waddr_i (s2_bi_q),
    .wdata_i (bim_new), .raddr_i (s2_bi_q), .rdata_i (bim_raw), .data_o (bim_cur)
  );

  hbdp_fwd #(.AW(IW), .DW(2)) u_lpt_fwd (
    .clk_i (clk_i), .rst_ni (rst_ni), .we_i (tb_we), .waddr_i (s2_lp_q),
    .wdata_i (lpt_new), .raddr_i (s2_lp_q), .rdata_i (lpt_raw), .data_o (lpt_cur)
  );

  hbdp_fwd #(.AW(IW), .DW(3)) u_xpt_fwd (
    .clk_i (clk_i), .rst_ni (rst_ni), .we_i (tb_we), .waddr_i (s2_xi_q),
    .wdata_i (xpt_new), .raddr_i (s2_xi_q), .rdata_i (xpt_raw), .data_o (xpt_cur)
  );

  hbdp_fwd #(.AW(IW), .DW(9)) u_gpc_fwd (
    .clk_i (clk_i), .rst_ni (rst_ni), .we_i (tb_we), .waddr_i (s2_gi_q),
    .wdata_i (gpc_new), .raddr_i (s2_gi_q), .rdata_i (gpc_raw), .data_o (gpc_cur)
  );

  // Predictions and table updates.
  logic       p_bim, p_loc, p_glb, p_xor, sel_glb, p_two, p_maj, p_tour;
  logic       loc_ok, glb_ok, xor_ok;
  logic [2:0] gpt_cur;
  logic [1:0] ch_lg, ch_gx, ch_xl;

  assign gpt_cur = gpc_cur[2:0];
  assign ch_lg   = gpc_cur[4:3];
  assign ch_gx   = gpc_cur[6:5];
  assign ch_xl   = gpc_cur[8:7];

  always_comb begin
    p_bim   = bim_cur >= Cnt2Taken;
    p_loc   = lpt_cur >= Cnt2Taken;
    p_glb   = gpt_cur >= Cnt3Taken;
    p_xor   = xpt_cur >= Cnt3Taken;
    sel_glb = ch_lg >= Cnt2Taken;
    p_two   = sel_glb ? p_glb : p_loc;
    p_maj   = (p_loc & p_glb) | (p_loc & p_xor) | (p_glb & p_xor);
    if (sel_glb) begin
      p_tour = (ch_gx >= Cnt2Taken) ? p_xor : p_glb;
    end else begin
      p_tour = (ch_xl >= Cnt2Taken) ? p_xor : p_loc;
    end
    loc_ok  = p_loc == s2_taken_q;
    glb_ok  = p_glb == s2_taken_q;
    xor_ok  = p_xor == s2_taken_q;
    bim_new = sat2(bim_cur, s2_taken_q);
    lpt_new = sat2(lpt_cur, s2_taken_q);
    xpt_new = sat3(xpt_cur, s2_taken_q);
    gpc_new = {train(ch_xl, loc_ok, xor_ok), train(ch_gx, glb_ok, xor_ok),
               train(ch_lg, loc_ok, glb_ok), sat3(gpt_cur, s2_taken_q)};
  end

  // Output register.
  logic [7:0] pred_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= s2_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (tb_we) begin
      pred_q <= {p_tour, p_maj, p_two, p_xor, p_glb, p_loc, p_bim, !s2_fwd_q};
    end
  end

  assign out_valid_o        = out_valid_q;
  assign pred_static_o      = pred_q[0];
  assign pred_bimodal_o     = pred_q[1];
  assign pred_local_o       = pred_q[2];
  assign pred_global_o      = pred_q[3];
  assign pred_xor_global_o  = pred_q[4];
  assign pred_chooser_two_o = pred_q[5];
  assign pred_majority_o    = pred_q[6];
  assign pred_tourney_o     = pred_q[7];

  // Checks on the clearing pass and the pipeline freeze.
  `HBDP_ASSERT_IMPL(a_no_accept_in_clear, clr_q, in_stall_o, "beat accepted during clear")
  `HBDP_ASSERT_NEVER(a_no_update_in_clear, clr_q && (s1_valid_q || s2_valid_q), "busy in clear")
  `HBDP_ASSERT_IMPL(a_freeze, out_valid_q && out_stall_i, ##1 $stable(s2_valid_q),
                    "pipeline moved while output stalled")

endmodule

`default_nettype wire
